// File: hw/rtl/crre_pkg.sv
// Shared types, request codes and helpers for the clip rectangle region engine.
`timescale 1ns / 1ps
`default_nettype none
package crre_pkg;

    localparam int MAX_RECTS_DEF = 64;
    localparam int OUT_CAP       = 64;
    localparam int OUT_CAP_W     = $clog2(OUT_CAP + 1);

    localparam logic [2:0] REQ_SUB   = 3'd0;
    localparam logic [2:0] REQ_ADD   = 3'd1;
    localparam logic [2:0] REQ_INT   = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_FILL  = 3'd4;

    localparam logic CFG_OFFSET_X = 1'b0;
    localparam logic CFG_OFFSET_Y = 1'b1;

    localparam logic signed [17:0] PLANE_MIN = -18'sd32768;
    localparam logic signed [17:0] PLANE_MAX = 18'sd32767;

    // inclusive corner box
    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
    } t_box;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic [31:0]        fill_color;
    } t_in;

    typedef struct packed {
        logic               has_rect;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [14:0]        out_w;
        logic [14:0]        out_h;
        logic [31:0]        out_color;
        logic               table_overflow;
        logic               last;
    } t_out;

    function automatic t_out make_out(input logic has, input t_box bx,
                                      input logic [31:0] color,
                                      input logic ovf, input logic lst);
        t_out        o;
        logic [16:0] dw;
        logic [16:0] dh;
        dw = {bx.r[15], bx.r} - {bx.l[15], bx.l} + 17'd1;
        dh = {bx.b[15], bx.b} - {bx.t[15], bx.t} + 17'd1;
        o.has_rect       = has;
        o.out_x          = has ? bx.l : 16'sd0;
        o.out_y          = has ? bx.t : 16'sd0;
        o.out_w          = has ? dw[14:0] : 15'd0;
        o.out_h          = has ? dh[14:0] : 15'd0;
        o.out_color      = color;
        o.table_overflow = ovf;
        o.last           = lst;
        return o;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/crre_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module crre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/crre_geom.sv
// Box geometry: overlap of an entry with the request and its four split strips.
`timescale 1ns / 1ps
`default_nettype none
module crre_geom
    import crre_pkg::*;
(
    input  wire t_box       i_g,
    input  wire t_box       i_c,
    output t_box            o_ovl,
    output logic            o_ovl_ok,
    output t_box      [3:0] o_piece,
    output logic      [3:0] o_piece_ok
);
    always_comb begin
        o_ovl.l  = (i_g.l > i_c.l) ? i_g.l : i_c.l;
        o_ovl.t  = (i_g.t > i_c.t) ? i_g.t : i_c.t;
        o_ovl.r  = (i_g.r < i_c.r) ? i_g.r : i_c.r;
        o_ovl.b  = (i_g.b < i_c.b) ? i_g.b : i_c.b;
        o_ovl_ok = (o_ovl.l <= o_ovl.r) && (o_ovl.t <= o_ovl.b);
    end

    // strips in order left, top, right, bottom; the remainder shrinks as each strip is cut off
    always_comb begin
        logic signed [16:0] gl, gt, gr, gb, cl, ct, cr, cb;
        logic signed [16:0] pl, pt, pr, pb;
        gl = 17'(i_g.l); gt = 17'(i_g.t); gr = 17'(i_g.r); gb = 17'(i_g.b);
        cl = 17'(i_c.l); ct = 17'(i_c.t); cr = 17'(i_c.r); cb = 17'(i_c.b);
        o_piece    = '0;
        o_piece_ok = '0;
        for (int k = 0; k < 4; k++) begin
            pl = gl; pt = gt; pr = gr; pb = gb;
            o_piece_ok[k] = 1'b0;
            case (k)
                0: begin
                    if (cl >= gl && cl <= gr) begin
                        pr = cl - 17'sd1; o_piece_ok[k] = 1'b1; gl = cl;
                    end
                end
                1: begin
                    if (ct >= gt && ct <= gb) begin
                        pb = ct - 17'sd1; o_piece_ok[k] = 1'b1; gt = ct;
                    end
                end
                2: begin
                    if (cr >= gl && cr <= gr) begin
                        pl = cr + 17'sd1; o_piece_ok[k] = 1'b1; gr = cr;
                    end
                end
                default: begin
                    if (cb >= gt && cb <= gb) begin
                        pt = cb + 17'sd1; o_piece_ok[k] = 1'b1; gb = cb;
                    end
                end
            endcase
            o_piece_ok[k] = o_piece_ok[k] && (pl <= pr) && (pt <= pb);
            o_piece[k]    = '{l: pl[15:0], t: pt[15:0], r: pr[15:0], b: pb[15:0]};
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/clip_rect_region_engine.sv
// Top level of the clip rectangle region engine: request sequencer around the clip table RAM.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in  (t_in)
//  out       output     o_out_valid / i_out_ready  o_out (t_out)
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  One request transaction at a time. Each table entry visited takes a RAM read
//  (S_SCAN), then an evaluate (S_EVAL); a split moves each entry above it down
//  (S_SHRD read, S_SHWR write), ends the shift and takes the four pieces in turn
//  (S_PIECE), then the scan restarts from entry zero. Requests end in S_FIN.
//  Reset (synchronous, active low) empties the table and lowers the clip flag;
//  the RAM is never cleared. A full output register stalls the sequencer.
//
module clip_rect_region_engine
    import crre_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_RECTS);
    localparam int CW = $clog2(MAX_RECTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_SHRD   = 3'd3;
    localparam logic [2:0] S_SHWR   = 3'd4;
    localparam logic [2:0] S_PIECE  = 3'd5;
    localparam logic [2:0] S_APPEND = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_active, n_active;
    logic signed [15:0]   r_ofs_x, r_ofs_y;
    logic [2:0]           r_type, n_type;
    t_box                 r_req, n_req;
    logic                 r_req_empty, n_req_empty;
    logic [31:0]          r_color, n_color;
    logic                 r_ovf, n_ovf;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_wr, n_wr;
    logic [CW-1:0]        r_mv, n_mv;
    logic [1:0]           r_pc, n_pc;
    t_box                 r_g, n_g;
    logic                 r_pend, n_pend;
    t_box                 r_pend_box, n_pend_box;
    logic [OUT_CAP_W-1:0] r_nemit, n_nemit;
    logic                 r_out_valid;
    t_out                 r_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_box          ram_wdata, ram_rdata;
    logic [CW-1:0] mv_next;

    t_box       g_in, ovl;
    logic       ovl_ok, hit;
    t_box [3:0] piece;
    logic [3:0] piece_ok;

    logic       push;
    t_out       push_d;
    logic       out_free;

    // request box, offset for fill, clamped to the plane
    logic signed [17:0] q_l, q_t, q_r, q_b, ox, oy;
    logic               q_empty;

    assign mv_next   = r_mv + CW'(1);
    assign ram_raddr = (r_state == S_SHRD || r_state == S_SHWR) ? mv_next[AW-1:0]
                                                                : r_idx[AW-1:0];

    crre_ram #(.WIDTH($bits(t_box)), .DEPTH(MAX_RECTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign g_in = (r_state == S_PIECE) ? r_g : ram_rdata;

    crre_geom u_geom (
        .i_g        (g_in),
        .i_c        (r_req),
        .o_ovl      (ovl),
        .o_ovl_ok   (ovl_ok),
        .o_piece    (piece),
        .o_piece_ok (piece_ok)
    );

    assign hit      = ovl_ok && !r_req_empty;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        ox = (i_in.req_type == REQ_FILL) ? 18'(r_ofs_x) : 18'sd0;
        oy = (i_in.req_type == REQ_FILL) ? 18'(r_ofs_y) : 18'sd0;
        q_l = 18'(i_in.rect_x) + ox;
        q_t = 18'(i_in.rect_y) + oy;
        q_r = 18'(i_in.rect_x) + $signed({3'b000, i_in.rect_w}) - 18'sd1 + ox;
        q_b = 18'(i_in.rect_y) + $signed({3'b000, i_in.rect_h}) - 18'sd1 + oy;
        if (q_l < PLANE_MIN) q_l = PLANE_MIN;
        if (q_t < PLANE_MIN) q_t = PLANE_MIN;
        if (q_r > PLANE_MAX) q_r = PLANE_MAX;
        if (q_b > PLANE_MAX) q_b = PLANE_MAX;
        q_empty = (q_l > q_r) || (q_t > q_b);
    end

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_active = r_active;
        n_type = r_type;     n_req = r_req;       n_req_empty = r_req_empty;
        n_color = r_color;   n_ovf = r_ovf;       n_idx = r_idx;
        n_wr = r_wr;         n_mv = r_mv;         n_pc = r_pc;
        n_g = r_g;           n_pend = r_pend;     n_pend_box = r_pend_box;
        n_nemit = r_nemit;
        ram_we = 1'b0;  ram_waddr = r_idx[AW-1:0];  ram_wdata = ovl;
        push = 1'b0;    push_d = '0;
        o_in_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_type      = i_in.req_type;
                    n_req       = '{l: q_l[15:0], t: q_t[15:0], r: q_r[15:0], b: q_b[15:0]};
                    n_req_empty = q_empty;
                    n_color     = i_in.fill_color;
                    n_ovf = 1'b0;  n_idx = '0;  n_wr = '0;
                    n_pend = 1'b0; n_nemit = '0;
                    case (i_in.req_type)
                        REQ_SUB, REQ_ADD, REQ_INT: begin
                            n_active = 1'b1;
                            n_state  = S_SCAN;
                        end
                        REQ_CLEAR: begin
                            n_count  = '0;
                            n_active = 1'b0;
                            n_state  = S_FIN;
                        end
                        REQ_FILL: begin
                            if (r_count == '0) begin
                                // no table: whole rectangle only while clipping is off
                                n_pend     = !r_active && !q_empty;
                                n_pend_box = n_req;
                                n_nemit    = OUT_CAP_W'(n_pend);
                                n_state    = S_FIN;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx < r_count &&
                    !(r_type == REQ_FILL && r_nemit == OUT_CAP_W'(OUT_CAP))) begin
                    n_state = S_EVAL;
                end else begin
                    if (r_type == REQ_INT) n_count = r_wr;
                    n_state = (r_type == REQ_ADD) ? S_APPEND : S_FIN;
                end
            end
            S_EVAL: begin
                case (r_type)
                    REQ_FILL: begin
                        if (!hit) begin
                            n_idx = r_idx + CW'(1); n_state = S_SCAN;
                        end else if (!r_pend || out_free) begin
                            // previous overlap goes out; this one waits to learn if it is last
                            push   = r_pend;
                            push_d = make_out(1'b1, r_pend_box, r_color, 1'b0, 1'b0);
                            n_pend = 1'b1;  n_pend_box = ovl;
                            n_nemit = r_nemit + OUT_CAP_W'(1);
                            n_idx = r_idx + CW'(1); n_state = S_SCAN;
                        end
                    end
                    REQ_INT: begin
                        if (hit) begin
                            ram_we = 1'b1; ram_waddr = r_wr[AW-1:0]; ram_wdata = ovl;
                            n_wr = r_wr + CW'(1);
                        end
                        n_idx = r_idx + CW'(1); n_state = S_SCAN;
                    end
                    default: begin
                        if (hit) begin
                            n_g = ram_rdata; n_mv = r_idx; n_state = S_SHRD;
                        end else begin
                            n_idx = r_idx + CW'(1); n_state = S_SCAN;
                        end
                    end
                endcase
            end
            S_SHRD: begin
                // close the gap: entries above the hit slide down one place
                if (mv_next < r_count) begin
                    n_state = S_SHWR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_pc = 2'd0; n_state = S_PIECE;
                end
            end
            S_SHWR: begin
                ram_we = 1'b1; ram_waddr = r_mv[AW-1:0]; ram_wdata = ram_rdata;
                n_mv = mv_next; n_state = S_SHRD;
            end
            S_PIECE: begin
                if (piece_ok[r_pc]) begin
                    if (r_count < CW'(MAX_RECTS)) begin
                        ram_we = 1'b1; ram_waddr = r_count[AW-1:0]; ram_wdata = piece[r_pc];
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                if (r_pc == 2'd3) begin
                    n_idx = '0; n_state = S_SCAN;
                end else begin
                    n_pc = r_pc + 2'd1;
                end
            end
            S_APPEND: begin
                if (!r_req_empty) begin
                    if (r_count < CW'(MAX_RECTS)) begin
                        ram_we = 1'b1; ram_waddr = r_count[AW-1:0]; ram_wdata = r_req;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_FIN;
            end
            default: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_type == REQ_FILL) begin
                        push_d = make_out(r_pend, r_pend_box, r_color, 1'b0, 1'b1);
                    end else begin
                        push_d = make_out(1'b0, r_req, 32'd0, r_ovf, 1'b1);
                    end
                    n_pend = 1'b0; n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_ofs_x     <= '0;
            r_ofs_y     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_active <= n_active;
            r_pend   <= n_pend;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OFFSET_X) r_ofs_x <= i_cfg_data;
                if (i_cfg_idx == CFG_OFFSET_Y) r_ofs_y <= i_cfg_data;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type      <= n_type;
        r_req       <= n_req;
        r_req_empty <= n_req_empty;
        r_color     <= n_color;
        r_ovf       <= n_ovf;
        r_idx       <= n_idx;
        r_wr        <= n_wr;
        r_mv        <= n_mv;
        r_pc        <= n_pc;
        r_g         <= n_g;
        r_pend_box  <= n_pend_box;
        r_nemit     <= n_nemit;
        if (push) r_out <= push_d;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
`default_nettype wire

// File: tb/clip_rect_region_engine_tb.sv
// Self-checking testbench for the clip rectangle region engine.
`timescale 1ns / 1ps

module clip_rect_region_engine_tb
    import crre_pkg::*;
();

    localparam int TABLE_DEPTH = MAX_RECTS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 2000;
    localparam int SETTLE_CYCLES = 300;

    // Region predictor plus the queue of results it still owes.
    class region_scoreboard;
        int     bl[TABLE_DEPTH];
        int     bt[TABLE_DEPTH];
        int     br[TABLE_DEPTH];
        int     bb[TABLE_DEPTH];
        int     count;
        bit     active;
        int     off_x;
        int     off_y;
        bit     dropped;
        t_out   owed_q[$];

        function new();
            count = 0;
            active = 0;
            off_x = 0;
            off_y = 0;
        endfunction

        function void set_offsets(int ox, int oy);
            off_x = ox;
            off_y = oy;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void put(int l, int t, int r, int b);
            if (l > r || t > b) return;
            if (count >= TABLE_DEPTH) begin
                dropped = 1;
                return;
            end
            bl[count] = l; bt[count] = t; br[count] = r; bb[count] = b;
            count++;
        endfunction

        function void remove_entry(int i);
            for (int j = i; j < count - 1; j++) begin
                bl[j] = bl[j+1]; bt[j] = bt[j+1]; br[j] = br[j+1]; bb[j] = bb[j+1];
            end
            count--;
        endfunction

        // left, top, right, bottom strips in that order
        function void split(int gl, int gt, int gr, int gb, int cl, int ct, int cr, int cb);
            if (cl >= gl && cl <= gr) begin
                put(gl, gt, cl - 1, gb);
                gl = cl;
            end
            if (ct >= gt && ct <= gb) begin
                put(gl, gt, gr, ct - 1);
                gt = ct;
            end
            if (cr >= gl && cr <= gr) begin
                put(cr + 1, gt, gr, gb);
                gr = cr;
            end
            if (cb >= gt && cb <= gb) begin
                put(gl, cb + 1, gr, gb);
                gb = cb;
            end
        endfunction

        function bit overlaps(int i, int l, int t, int r, int b);
            return (((bl[i] > l) ? bl[i] : l) <= ((br[i] < r) ? br[i] : r)) &&
                   (((bt[i] > t) ? bt[i] : t) <= ((bb[i] < b) ? bb[i] : b));
        endfunction

        function void subtract(int l, int t, int r, int b);
            int i;
            i = 0;
            active = 1;
            while (i < count) begin
                if (!overlaps(i, l, t, r, b)) begin
                    i++;
                end else begin
                    int gl, gt, gr, gb;
                    gl = bl[i]; gt = bt[i]; gr = br[i]; gb = bb[i];
                    remove_entry(i);
                    split(gl, gt, gr, gb, l, t, r, b);
                    i = 0;
                end
            end
        endfunction

        function t_out make_result(bit has, int l, int t, int r, int b, logic [31:0] color);
            t_out o;
            int   dw, dh;
            dw = r - l + 1;
            dh = b - t + 1;
            o.has_rect       = has;
            o.out_x          = has ? l[15:0] : 16'sd0;
            o.out_y          = has ? t[15:0] : 16'sd0;
            o.out_w          = has ? dw[14:0] : 15'd0;
            o.out_h          = has ? dh[14:0] : 15'd0;
            o.out_color      = color;
            o.table_overflow = dropped;
            o.last           = 1'b0;
            return o;
        endfunction

        function void note_request(t_in it);
            int   l, t, r, b, n;
            t_out res[$];
            t_out tail;
            dropped = 0;
            l = int'(it.rect_x);
            t = int'(it.rect_y);
            r = l + int'(it.rect_w) - 1;
            b = t + int'(it.rect_h) - 1;
            if (it.req_type == REQ_FILL) begin
                l += off_x; r += off_x; t += off_y; b += off_y;
            end
            // saturate to the signed 16-bit plane
            if (l < -32768) l = -32768;
            if (t < -32768) t = -32768;
            if (r > 32767) r = 32767;
            if (b > 32767) b = 32767;
            if (it.req_type == REQ_FILL) begin
                if (count > 0) begin
                    for (int i = 0; i < count && res.size() < OUT_CAP; i++) begin
                        if (overlaps(i, l, t, r, b))
                            res.push_back(make_result(1'b1,
                                (bl[i] > l) ? bl[i] : l, (bt[i] > t) ? bt[i] : t,
                                (br[i] < r) ? br[i] : r, (bb[i] < b) ? bb[i] : b,
                                it.fill_color));
                    end
                end else if (!active && l <= r && t <= b) begin
                    res.push_back(make_result(1'b1, l, t, r, b, it.fill_color));
                end
                if (res.size() == 0)
                    res.push_back(make_result(1'b0, l, t, r, b, it.fill_color));
            end else begin
                case (it.req_type)
                    REQ_SUB: subtract(l, t, r, b);
                    REQ_ADD: begin
                        subtract(l, t, r, b);
                        put(l, t, r, b);
                    end
                    REQ_INT: begin
                        active = 1;
                        n = 0;
                        for (int i = 0; i < count; i++) begin
                            if (overlaps(i, l, t, r, b)) begin
                                bl[n] = (bl[i] > l) ? bl[i] : l;
                                bt[n] = (bt[i] > t) ? bt[i] : t;
                                br[n] = (br[i] < r) ? br[i] : r;
                                bb[n] = (bb[i] < b) ? bb[i] : b;
                                n++;
                            end
                        end
                        count = n;
                    end
                    REQ_CLEAR: begin
                        count = 0;
                        active = 0;
                    end
                    default: ;
                endcase
                res.push_back(make_result(1'b0, l, t, r, b, 32'd0));
            end
            tail = res.pop_back();
            tail.last = 1'b1;
            res.push_back(tail);
            foreach (res[k]) owed_q.push_back(res[k]);
        endfunction

        // empty string when the result matches the oldest one owed
        function string check_result(t_out got);
            t_out  e;
            string s;
            if (owed_q.size() == 0)
                return $sformatf("result with nothing owed: %p", got);
            e = owed_q.pop_front();
            s = "";
            if (got.has_rect !== e.has_rect)
                s = {s, $sformatf(" has_rect %0d/%0d", got.has_rect, e.has_rect)};
            if (got.out_x !== e.out_x)
                s = {s, $sformatf(" out_x %0d/%0d", got.out_x, e.out_x)};
            if (got.out_y !== e.out_y)
                s = {s, $sformatf(" out_y %0d/%0d", got.out_y, e.out_y)};
            if (got.out_w !== e.out_w)
                s = {s, $sformatf(" out_w %0d/%0d", got.out_w, e.out_w)};
            if (got.out_h !== e.out_h)
                s = {s, $sformatf(" out_h %0d/%0d", got.out_h, e.out_h)};
            if (got.out_color !== e.out_color)
                s = {s, $sformatf(" out_color %h/%h", got.out_color, e.out_color)};
            if (got.table_overflow !== e.table_overflow)
                s = {s, $sformatf(" overflow %0d/%0d", got.table_overflow, e.table_overflow)};
            if (got.last !== e.last)
                s = {s, $sformatf(" last %0d/%0d", got.last, e.last)};
            if (s != "")
                s = {"field mismatch (got/exp):", s};
            return s;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;

    region_scoreboard clip_sb = new();

    int  fail_count = 0;
    int  cycle_count = 0;
    int  req_count = 0;
    int  result_count = 0;
    int  overflow_seen = 0;
    int  drawn_seen = 0;
    bit  idle_on = 1'b0;
    bit  hold_req = 1'b0;

    clip_rect_region_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, clip_sb.pending());
            $display("clip_rect_region_engine test failed");
            $finish;
        end
    end

    task automatic report(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    // Accepted request transactions feed the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            clip_sb.note_request(i_in);
            req_count++;
        end
    end

    // Accepted result transactions are checked against the oldest owed result.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            msg = clip_sb.check_result(o_out);
            result_count++;
            if (o_out.table_overflow) overflow_seen++;
            if (o_out.has_rect) drawn_seen++;
            if (msg != "") report(msg);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic t_in make_req(logic [2:0] op, int x, int y, int w, int h,
                                     logic [31:0] color);
        t_in it;
        it.req_type   = op;
        it.rect_x     = x[15:0];
        it.rect_y     = y[15:0];
        it.rect_w     = w[14:0];
        it.rect_h     = h[14:0];
        it.fill_color = color;
        return it;
    endfunction

    // Offer one request; valid stays up until the transaction completes.
    task automatic send_req(t_in it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
    endtask

    // Wait for every owed result, then let the sequencer settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (clip_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_offsets(int ox, int oy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OFFSET_X;
        i_cfg_data <= ox[15:0];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFFSET_Y;
        i_cfg_data <= oy[15:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        clip_sb.set_offsets(int'($signed(ox[15:0])), int'($signed(oy[15:0])));
    endtask

    // Random request: mostly small rectangles near the origin so entries
    // overlap, sometimes anything the fields allow.
    function automatic t_in rand_req(int span);
        int r, x, y, w, h;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 30)      op = REQ_ADD;
        else if (r < 45) op = REQ_SUB;
        else if (r < 52) op = REQ_INT;
        else if (r < 55) op = REQ_CLEAR;
        else if (r < 58) op = 3'(REQ_FILL + $urandom_range(1, 3));
        else             op = REQ_FILL;
        if ($urandom_range(0, 15) == 0) begin
            x = $urandom_range(0, 65535) - 32768;
            y = $urandom_range(0, 65535) - 32768;
            w = $urandom_range(0, 32767);
            h = $urandom_range(0, 32767);
        end else begin
            x = $urandom_range(0, 2 * span) - span;
            y = $urandom_range(0, 2 * span) - span;
            w = $urandom_range(0, span);
            h = $urandom_range(0, span);
        end
        return make_req(op, x, y, w, h, $urandom());
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, flag, saturation, splits, unused codes.
        set_offsets(0, 0);
        send_req(make_req(REQ_FILL, 0, 0, 10, 10, 32'h1234_5678));
        send_req(make_req(REQ_FILL, 5, 5, 0, 7, 32'h0));
        send_req(make_req(REQ_FILL, 32767, 32767, 32767, 32767, 32'hFFFF_FFFF));
        send_req(make_req(REQ_SUB, 0, 0, 4, 4, 32'hA5A5_A5A5));
        send_req(make_req(REQ_FILL, 0, 0, 10, 10, 32'h5A5A_5A5A));
        send_req(make_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0));
        send_req(make_req(REQ_ADD, -32768, -32768, 32767, 32767, 32'h0));
        send_req(make_req(REQ_ADD, 3, 3, 0, 0, 32'h0));
        send_req(make_req(REQ_ADD, 10, 10, 20, 20, 32'h0));
        send_req(make_req(REQ_SUB, 15, 15, 3, 3, 32'h0));
        send_req(make_req(REQ_FILL, 0, 0, 100, 100, 32'hFFFF_FFFF));
        send_req(make_req(REQ_INT, 12, 12, 10, 10, 32'h0));
        send_req(make_req(REQ_FILL, -40, -40, 32767, 32767, 32'h0F0F_0F0F));
        for (int k = 1; k <= 3; k++)
            send_req(make_req(3'(REQ_FILL + k), 1, 2, 3, 4, 32'hDEAD_BEEF));
        send_req(make_req(REQ_INT, 30000, 30000, 5, 5, 32'h0));
        send_req(make_req(REQ_FILL, 0, 0, 50, 50, 32'h0000_0001));
        send_req(make_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0));
        send_req(make_req(REQ_ADD, 32767, 32767, 32767, 32767, 32'h0));
        send_req(make_req(REQ_FILL, 32767, 32767, 1, 1, 32'h8000_0000));
        send_req(make_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0));
        drain();

        // Random mix with idling on both sides.
        idle_on = 1'b1;
        for (int n = 0; n < 85; n++) send_req(rand_req(60));
        drain();

        // Offset extremes: push filled rectangles against the plane edges.
        set_offsets(32767, -32768);
        send_req(make_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0));
        send_req(make_req(REQ_FILL, 0, 0, 5, 5, 32'h1111_1111));
        send_req(make_req(REQ_FILL, -32768, 32767, 32767, 32767, 32'h2222_2222));
        for (int n = 0; n < 50; n++) send_req(rand_req(60));
        drain();
        set_offsets(-32768, 32767);
        send_req(make_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0));
        send_req(make_req(REQ_FILL, 32767, -32768, 32767, 32767, 32'h3333_3333));
        for (int n = 0; n < 40; n++) send_req(rand_req(60));
        drain();

        // Build up a crowded table, then carve it so splits overrun it.
        set_offsets($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
        send_req(make_req(REQ_CLEAR, 0, 0, 0, 0, 32'h0));
        for (int n = 0; n < 80; n++)
            send_req(make_req(REQ_ADD, $urandom_range(0, 300), $urandom_range(0, 300),
                              $urandom_range(1, 12), $urandom_range(1, 12), 32'h0));
        send_req(make_req(REQ_FILL, 0, 0, 320, 320, $urandom()));
        hold_req = 1'b1;
        for (int n = 0; n < 30; n++) begin
            if ($urandom_range(0, 1) == 0)
                send_req(make_req(REQ_SUB, $urandom_range(0, 300), $urandom_range(0, 300),
                                  $urandom_range(1, 4), $urandom_range(1, 4), 32'h0));
            else
                send_req(make_req(REQ_FILL, $urandom_range(0, 300) - 40,
                                  $urandom_range(0, 300) - 40, $urandom_range(0, 200),
                                  $urandom_range(0, 200), $urandom()));
        end
        for (int n = 0; n < 20; n++) send_req(rand_req(150));
        drain();

        // Last stretch: random offsets, idling on both sides at first, then none.
        set_offsets($urandom_range(0, 65535), $urandom_range(0, 65535));
        for (int n = 0; n < 30; n++) send_req(rand_req(60));
        idle_on = 1'b0;
        for (int n = 0; n < 70; n++) send_req(rand_req(60));
        drain();

        $display("covered %0d requests, %0d results (%0d with a rectangle, %0d overflowed)",
                 req_count, result_count, drawn_seen, overflow_seen);
        $display("five offset settings including both plane extremes, %0d mismatches",
                 fail_count);
        if (fail_count == 0 && clip_sb.pending() == 0) begin
            $display("clip_rect_region_engine test passed");
        end else begin
            if (clip_sb.pending() != 0)
                report($sformatf("%0d results never arrived", clip_sb.pending()));
            $display("clip_rect_region_engine test failed");
        end
        $finish;
    end

endmodule
